// File: sv/smc420_pkg.sv
// shared types, constants and helpers for the stereo mask colorizer
package smc420_pkg;

	// default size of the mask store in bytes
	localparam int MASK_BUFFER_BYTES_DEF = 262144;

	// item commands
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_QUAD = 1'b1;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_MASK_LEFT   = 3'd0,
		REG_EYE_OFFSET  = 3'd1,
		REG_MASK_COLOR  = 3'd2,
		REG_MASK_WIDTH  = 3'd3,
		REG_MASK_HEIGHT = 3'd4,
		REG_OUT_WIDTH   = 3'd5
	} reg_idx_t;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	// reset colour: Y 0xff, U 0x80, V 0x80
	localparam logic [23:0] MASK_COLOR_RST = 24'hFF8080;

	// reciprocal of 255 scaled by 2^23, exact for 16-bit dividends
	localparam logic [15:0] RECIP_255 = 16'h8081;

	typedef struct packed {
		logic        command;
		logic [17:0] load_address;
		logic [7:0]  load_value;
		logic [10:0] quad_x;
		logic [10:0] quad_y;
		logic        eye;
	} item_t;

	typedef struct packed {
		logic [1:0]  pixel_index;
		logic [15:0] luma_weighted;
		logic [7:0]  inverse_alpha;
		logic [7:0]  letterbox_luma;
		logic [15:0] chroma_u_weighted;
		logic [15:0] chroma_v_weighted;
		logic [7:0]  chroma_inverse_alpha;
		logic [7:0]  letterbox_u;
		logic [7:0]  letterbox_v;
		logic        last;
	} result_t;

	// floor(x / 255) for x up to 65025
	function automatic logic [7:0] div255(input logic [15:0] x);
		logic [31:0] p;
		p = 32'(x) * 32'(RECIP_255);
		return p[30:23];
	endfunction

endpackage

// File: sv/smc420_if.sv
// channel interfaces: input items, result items and configuration writes

interface smc420_item_if;
	logic                valid;
	logic                ready;
	smc420_pkg::item_t   data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface smc420_result_if;
	logic                valid;
	logic                ready;
	smc420_pkg::result_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface smc420_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [smc420_pkg::CFG_IDX_W-1:0]    index;
	logic [smc420_pkg::CFG_DATA_W-1:0]   value;
	modport source (output valid, output index, output value, input ready);
	modport sink (input valid, input index, input value, output ready);
endinterface

// File: sv/stereo_mask_colorize_420.sv
// Stereo mask colorizer (4:2:0): load transactions write alpha bytes into an on-chip mask
// store; a quad transaction reads the four alphas of a 2x2 output block (shifted by the eye's
// mask position, clipped to the output width) and returns four pixel results with weighted
// luma and the quad's shared chroma. A quad holds the input while its pixels are read in
// turn, as the mask store has one read port and each pixel needs one read; quads sustain one
// result per cycle while the result side is ready. The store has no reset or clearing pass:
// every byte that a quad reads must have been loaded first. Configuration must be written by
// the user only while the block is idle, which the block does not check; cfg is always ready.
module stereo_mask_colorize_420 #(
	parameter int MASK_BUFFER_BYTES = smc420_pkg::MASK_BUFFER_BYTES_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	smc420_cfg_if.sink              cfg,
	smc420_item_if.sink             item,
	smc420_result_if.source         result
);

	localparam int AW = $clog2(MASK_BUFFER_BYTES);

	typedef struct packed {
		logic [3:0][7:0]  alpha;
		logic [9:0]       sum;
		logic [7:0]       inv_avg;
		logic [15:0]      wu;
		logic [15:0]      wv;
		logic [3:0][15:0] wy;
		logic [3:0][7:0]  lby;
		logic [15:0]      nu;
		logic [15:0]      nv;
		logic [7:0]       lu;
		logic [7:0]       lv;
	} quad_t;

	// configuration registers
	logic signed [12:0] mask_left_q;
	logic signed [12:0] eye_offset_q;
	logic [23:0]        mask_color_q;
	logic [12:0]        mask_width_q;
	logic [12:0]        mask_height_q;
	logic [12:0]        out_width_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_left_q   <= '0;
			eye_offset_q  <= '0;
			mask_color_q  <= smc420_pkg::MASK_COLOR_RST;
			mask_width_q  <= '0;
			mask_height_q <= '0;
			out_width_q   <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				smc420_pkg::REG_MASK_LEFT: begin
					mask_left_q <= cfg.value[12:0];
				end
				smc420_pkg::REG_EYE_OFFSET: begin
					eye_offset_q <= cfg.value[12:0];
				end
				smc420_pkg::REG_MASK_COLOR: begin
					mask_color_q <= cfg.value[23:0];
				end
				smc420_pkg::REG_MASK_WIDTH: begin
					mask_width_q <= cfg.value[12:0];
				end
				smc420_pkg::REG_MASK_HEIGHT: begin
					mask_height_q <= cfg.value[12:0];
				end
				smc420_pkg::REG_OUT_WIDTH: begin
					out_width_q <= cfg.value[12:0];
				end
				default: begin
				end
			endcase
		end
	end

	// stage valids and sequencing counters
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;
	logic [1:0] bk_q;
	logic [1:0] ser_q;
	logic       out_valid_q;

	// stage payloads
	smc420_pkg::item_t  item_s1;
	logic signed [13:0] pos_s1;
	logic               zone_s1;

	logic               pix_s2, ok_s2;
	logic [1:0]         k_s2;
	logic [11:0]        y_s2;
	logic [12:0]        rel_s2;
	logic [17:0]        lda_s2;
	logic [7:0]         ldv_s2;

	logic               pix_s3, ok_s3;
	logic [1:0]         k_s3;
	logic [24:0]        prod_s3;
	logic [12:0]        rel_s3;
	logic [17:0]        lda_s3;
	logic [7:0]         ldv_s3;

	logic               pix_s4, ok_s4;
	logic [1:0]         k_s4;
	logic [25:0]        addr_s4;
	logic [7:0]         ldv_s4;

	logic               pix_s5, ok_s5;
	logic [1:0]         k_s5;
	logic [7:0]         rd_s5;

	logic [3:0][7:0]    alpha_q;
	logic [9:0]         acc_q;

	quad_t              q_s6, q_s7, q_s8, q_s9;
	smc420_pkg::result_t out_q;

	// flow control: each stage loads when empty or when its content moves on
	logic out_en, pop9, emit;
	logic free2, free3, free4, free5, free6, free7, free8, free9;
	logic take5, issue, last_beat, accept;

	always_comb begin
		out_en    = !out_valid_q || result.ready;
		emit      = v_s9 && out_en;
		pop9      = emit && (ser_q == 2'd3);
		free9     = !v_s9 || pop9;
		free8     = !v_s8 || free9;
		free7     = !v_s7 || free8;
		free6     = !v_s6 || free7;
		take5     = v_s5 && (!pix_s5 || (k_s5 != 2'd3) || free6);
		free5     = !v_s5 || take5;
		free4     = !v_s4 || free5;
		free3     = !v_s3 || free4;
		free2     = !v_s2 || free3;
		last_beat = (item_s1.command == smc420_pkg::CMD_LOAD) || (bk_q == 2'd3);
		issue     = v_s1 && free2;
	end

	assign item.ready = !v_s1 || (free2 && last_beat);
	assign accept     = item.valid && item.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			v_s6        <= 1'b0;
			v_s7        <= 1'b0;
			v_s8        <= 1'b0;
			v_s9        <= 1'b0;
			bk_q        <= '0;
			ser_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				v_s1 <= 1'b1;
				bk_q <= '0;
			end else if (issue) begin
				bk_q <= bk_q + 2'd1;
				if (last_beat) begin
					v_s1 <= 1'b0;
				end
			end
			if (free2) v_s2 <= v_s1;
			if (free3) v_s3 <= v_s2;
			if (free4) v_s4 <= v_s3;
			if (free5) v_s5 <= v_s4;
			if (free6) v_s6 <= v_s5 && pix_s5 && (k_s5 == 2'd3);
			if (free7) v_s7 <= v_s6;
			if (free8) v_s8 <= v_s7;
			if (free9) v_s9 <= v_s8;
			if (emit) ser_q <= ser_q + 2'd1;
			if (out_en) out_valid_q <= v_s9;
		end
	end

	// stage 1: hold the item, precompute eye position and quad zone
	logic signed [13:0] pos_c;
	logic               zone_c;

	always_comb begin
		pos_c = 14'(mask_left_q);
		if (item.data.eye) begin
			pos_c = 14'(mask_left_q) + 14'(eye_offset_q);
		end
		zone_c = ({1'b0, item.data.quad_y} < mask_height_q[12:1])
			&& ({1'b0, item.data.quad_x} < out_width_q[12:1]);
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item.data;
			pos_s1  <= pos_c;
			zone_s1 <= zone_c;
		end
	end

	// beat expansion: pixel column relative to the mask edge and range check
	logic [11:0]        x_c;
	logic [11:0]        y_c;
	logic signed [14:0] rel_c;
	logic               inside_c;

	always_comb begin
		x_c      = {item_s1.quad_x, bk_q[0]};
		y_c      = {item_s1.quad_y, bk_q[1]};
		rel_c    = $signed({3'b000, x_c}) - 15'(pos_s1);
		inside_c = zone_s1 && !rel_c[14] && (rel_c[13:0] < {1'b0, mask_width_q});
	end

	always_ff @(posedge clk) begin
		if (free2) begin
			pix_s2 <= (item_s1.command == smc420_pkg::CMD_QUAD);
			ok_s2  <= (item_s1.command == smc420_pkg::CMD_LOAD) || inside_c;
			k_s2   <= bk_q;
			y_s2   <= y_c;
			rel_s2 <= rel_c[12:0];
			lda_s2 <= item_s1.load_address;
			ldv_s2 <= item_s1.load_value;
		end
	end

	// stage 3: row times mask width
	always_ff @(posedge clk) begin
		if (free3) begin
			pix_s3  <= pix_s2;
			ok_s3   <= ok_s2;
			k_s3    <= k_s2;
			prod_s3 <= 25'(y_s2) * 25'(mask_width_q);
			rel_s3  <= rel_s2;
			lda_s3  <= lda_s2;
			ldv_s3  <= ldv_s2;
		end
	end

	// stage 4: final store address and bounds check
	logic [25:0] addr_c;
	logic        ok_c;

	always_comb begin
		addr_c = pix_s3 ? (26'(prod_s3) + 26'(rel_s3)) : 26'(lda_s3);
		ok_c   = ok_s3 && (32'(addr_c) < 32'(MASK_BUFFER_BYTES));
	end

	always_ff @(posedge clk) begin
		if (free4) begin
			pix_s4  <= pix_s3;
			ok_s4   <= ok_c;
			k_s4    <= k_s3;
			addr_s4 <= addr_c;
			ldv_s4  <= ldv_s3;
		end
	end

	// mask store: loads write, pixel beats read, in transaction order
	logic [7:0]  mask_mem [MASK_BUFFER_BYTES];
	logic [31:0] addr_w;
	logic [AW-1:0] mem_idx;

	assign addr_w  = 32'(addr_s4);
	assign mem_idx = addr_w[AW-1:0];

	always_ff @(posedge clk) begin
		if (free5 && v_s4) begin
			if (!pix_s4 && ok_s4) begin
				mask_mem[mem_idx] <= ldv_s4;
			end
			rd_s5 <= mask_mem[mem_idx];
		end
	end

	always_ff @(posedge clk) begin
		if (free5) begin
			pix_s5 <= pix_s4;
			ok_s5  <= ok_s4;
			k_s5   <= k_s4;
		end
	end

	// stage 5: gather the four alphas of a quad
	logic [7:0] a5;
	quad_t      q6_c;

	assign a5 = ok_s5 ? rd_s5 : 8'd0;

	always_comb begin
		q6_c       = '0;
		q6_c.alpha = {a5, alpha_q[2], alpha_q[1], alpha_q[0]};
		q6_c.sum   = acc_q + 10'(a5);
	end

	always_ff @(posedge clk) begin
		if (take5 && pix_s5) begin
			alpha_q[k_s5] <= a5;
			acc_q <= (k_s5 == 2'd0) ? 10'(a5) : (acc_q + 10'(a5));
		end
		if (free6) q_s6 <= q6_c;
	end

	// stage 7: averages and colour weighting
	quad_t q7_c;
	logic [9:0] inv_sum_c;

	always_comb begin
		q7_c         = q_s6;
		inv_sum_c    = 10'd1020 - q_s6.sum;
		q7_c.inv_avg = inv_sum_c[9:2];
		q7_c.wu      = 16'(q_s6.sum[9:2]) * 16'(mask_color_q[15:8]);
		q7_c.wv      = 16'(q_s6.sum[9:2]) * 16'(mask_color_q[7:0]);
		for (int i = 0; i < 4; i++) begin
			q7_c.wy[i] = 16'(q_s6.alpha[i]) * 16'(mask_color_q[23:16]);
		end
	end

	always_ff @(posedge clk) begin
		if (free7) q_s7 <= q7_c;
	end

	// stage 8: letterbox luma and chroma numerators
	quad_t q8_c;

	always_comb begin
		q8_c    = q_s7;
		q8_c.nu = q_s7.wu + {1'b0, q_s7.inv_avg, 7'd0};
		q8_c.nv = q_s7.wv + {1'b0, q_s7.inv_avg, 7'd0};
		for (int i = 0; i < 4; i++) begin
			q8_c.lby[i] = smc420_pkg::div255(q_s7.wy[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (free8) q_s8 <= q8_c;
	end

	// stage 9: letterbox chroma
	quad_t q9_c;

	always_comb begin
		q9_c    = q_s8;
		q9_c.lu = smc420_pkg::div255(q_s8.nu);
		q9_c.lv = smc420_pkg::div255(q_s8.nv);
	end

	always_ff @(posedge clk) begin
		if (free9) q_s9 <= q9_c;
	end

	// output register: one pixel result per handshake, four per quad
	always_ff @(posedge clk) begin
		if (emit) begin
			out_q.pixel_index          <= ser_q;
			out_q.luma_weighted        <= q_s9.wy[ser_q];
			out_q.inverse_alpha        <= 8'd255 - q_s9.alpha[ser_q];
			out_q.letterbox_luma       <= q_s9.lby[ser_q];
			out_q.chroma_u_weighted    <= q_s9.wu;
			out_q.chroma_v_weighted    <= q_s9.wv;
			out_q.chroma_inverse_alpha <= q_s9.inv_avg;
			out_q.letterbox_u          <= q_s9.lu;
			out_q.letterbox_v          <= q_s9.lv;
			out_q.last                 <= (ser_q == 2'd3);
		end
	end

	assign result.valid = out_valid_q;
	assign result.data  = out_q;

`ifndef SYNTHESIS
	// the result counter is back at the first pixel whenever no quad waits
	assert property (@(posedge clk) disable iff (!arst_n) !v_s9 |-> (ser_q == 2'd0))
		else $error("result counter not aligned to quad boundary");

	// the input is only taken when the expander is empty or finishing its item
	assert property (@(posedge clk) disable iff (!arst_n)
		item.ready |-> (!v_s1 || (free2 && last_beat)))
		else $error("input taken while expander busy");

	// last marks the fourth result of a quad and nothing else
	assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.data.last == (result.data.pixel_index == 2'd3)))
		else $error("last flag out of step with pixel index");
`endif

endmodule

// File: bench/stereo_mask_colorize_420_tb.sv
// self-checking testbench for the stereo mask colorizer: directed table, then random phases
module stereo_mask_colorize_420_tb;

	localparam int N_STEPS = 42;
	localparam int RANDOM_ITEMS = 120;
	localparam int SETTLE_CYCLES = 24;
	localparam int CYCLE_LIMIT = 400000;

	// quad results that can be read off directly: all four alphas equal
	localparam smc420_pkg::result_t QUAD_CLEAR = '{pixel_index: 2'd0, luma_weighted: 16'd0,
		inverse_alpha: 8'd255, letterbox_luma: 8'd0, chroma_u_weighted: 16'd0,
		chroma_v_weighted: 16'd0, chroma_inverse_alpha: 8'd255, letterbox_u: 8'd128,
		letterbox_v: 8'd128, last: 1'b0};
	localparam smc420_pkg::result_t QUAD_OPAQUE_RESET_COLOR = '{pixel_index: 2'd0,
		luma_weighted: 16'd65025, inverse_alpha: 8'd0, letterbox_luma: 8'd255,
		chroma_u_weighted: 16'd32640, chroma_v_weighted: 16'd32640,
		chroma_inverse_alpha: 8'd0, letterbox_u: 8'd128, letterbox_v: 8'd128, last: 1'b0};
	localparam smc420_pkg::result_t QUAD_OPAQUE_WHITE = '{pixel_index: 2'd0,
		luma_weighted: 16'd65025, inverse_alpha: 8'd0, letterbox_luma: 8'd255,
		chroma_u_weighted: 16'd65025, chroma_v_weighted: 16'd65025,
		chroma_inverse_alpha: 8'd0, letterbox_u: 8'd255, letterbox_v: 8'd255, last: 1'b0};
	localparam smc420_pkg::result_t QUAD_OPAQUE_BLACK = '0;

	typedef enum logic [1:0] {STEP_CFG, STEP_LOAD, STEP_QUAD} step_kind_t;

	// a: register index, load address or quad column; b: value, byte or quad row
	typedef struct {
		step_kind_t          kind;
		int                  a;
		int                  b;
		bit                  eye_sel;
		bit                  typed;
		smc420_pkg::result_t want;
	} dir_step_t;

	dir_step_t steps [N_STEPS] = '{
		'{STEP_QUAD, 0, 0, 1'b0, 1'b1, QUAD_CLEAR},
		'{STEP_CFG, smc420_pkg::REG_MASK_WIDTH, 2, 1'b0, 1'b0, '0},
		'{STEP_CFG, smc420_pkg::REG_MASK_HEIGHT, 2, 1'b0, 1'b0, '0},
		'{STEP_CFG, smc420_pkg::REG_OUT_WIDTH, 4, 1'b0, 1'b0, '0},
		'{STEP_LOAD, 0, 255, 1'b0, 1'b0, '0},
		'{STEP_LOAD, 1, 255, 1'b0, 1'b0, '0},
		'{STEP_LOAD, 2, 255, 1'b0, 1'b0, '0},
		'{STEP_LOAD, 3, 255, 1'b0, 1'b0, '0},
		'{STEP_QUAD, 0, 0, 1'b0, 1'b1, QUAD_OPAQUE_RESET_COLOR},
		'{STEP_CFG, smc420_pkg::REG_MASK_COLOR, 'hFFFFFF, 1'b0, 1'b0, '0},
		'{STEP_QUAD, 0, 0, 1'b1, 1'b1, QUAD_OPAQUE_WHITE},
		'{STEP_CFG, smc420_pkg::REG_MASK_COLOR, 0, 1'b0, 1'b0, '0},
		'{STEP_QUAD, 0, 0, 1'b0, 1'b1, QUAD_OPAQUE_BLACK},
		'{STEP_CFG, smc420_pkg::REG_MASK_COLOR, 'h3C5AA7, 1'b0, 1'b0, '0},
		'{STEP_LOAD, 1, 0, 1'b0, 1'b0, '0},
		'{STEP_LOAD, 2, 1, 1'b0, 1'b0, '0},
		'{STEP_LOAD, 3, 128, 1'b0, 1'b0, '0},
		'{STEP_QUAD, 0, 0, 1'b0, 1'b0, '0},
		// right of the mask, beyond the output width, below the mask rows
		'{STEP_QUAD, 1, 0, 1'b0, 1'b1, QUAD_CLEAR},
		'{STEP_QUAD, 2, 0, 1'b1, 1'b1, QUAD_CLEAR},
		'{STEP_QUAD, 0, 1, 1'b0, 1'b1, QUAD_CLEAR},
		// odd shifts split the quad across the mask edge
		'{STEP_CFG, smc420_pkg::REG_MASK_LEFT, 1, 1'b0, 1'b0, '0},
		'{STEP_QUAD, 0, 0, 1'b0, 1'b0, '0},
		'{STEP_CFG, smc420_pkg::REG_EYE_OFFSET, 'h1FFF, 1'b0, 1'b0, '0},
		'{STEP_QUAD, 0, 0, 1'b1, 1'b0, '0},
		'{STEP_QUAD, 1, 0, 1'b0, 1'b0, '0},
		// largest mask and output
		'{STEP_CFG, smc420_pkg::REG_MASK_WIDTH, 4096, 1'b0, 1'b0, '0},
		'{STEP_CFG, smc420_pkg::REG_MASK_HEIGHT, 4096, 1'b0, 1'b0, '0},
		'{STEP_CFG, smc420_pkg::REG_OUT_WIDTH, 4096, 1'b0, 1'b0, '0},
		'{STEP_CFG, smc420_pkg::REG_MASK_LEFT, 0, 1'b0, 1'b0, '0},
		'{STEP_CFG, smc420_pkg::REG_EYE_OFFSET, 'h1000, 1'b0, 1'b0, '0},
		'{STEP_LOAD, 262143, 254, 1'b0, 1'b0, '0},
		'{STEP_QUAD, 2047, 31, 1'b0, 1'b0, '0},
		// mask address past the end of the store, then shifts at the ends of their range
		'{STEP_QUAD, 2047, 2047, 1'b0, 1'b1, QUAD_CLEAR},
		'{STEP_QUAD, 2047, 2047, 1'b1, 1'b1, QUAD_CLEAR},
		'{STEP_CFG, smc420_pkg::REG_MASK_LEFT, 'h0FFF, 1'b0, 1'b0, '0},
		'{STEP_CFG, smc420_pkg::REG_EYE_OFFSET, 'h0FFF, 1'b0, 1'b0, '0},
		'{STEP_QUAD, 0, 0, 1'b1, 1'b1, QUAD_CLEAR},
		'{STEP_QUAD, 2047, 0, 1'b0, 1'b0, '0},
		'{STEP_CFG, smc420_pkg::REG_MASK_LEFT, 'h1000, 1'b0, 1'b0, '0},
		'{STEP_QUAD, 0, 0, 1'b0, 1'b1, QUAD_CLEAR},
		'{STEP_QUAD, 0, 1, 1'b1, 1'b0, '0}
	};

	logic clk = 1'b0;
	logic arst_n;

	smc420_cfg_if    cfg_ch ();
	smc420_item_if   item_ch ();
	smc420_result_if res_ch ();

	stereo_mask_colorize_420 dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.item   (item_ch),
		.result (res_ch)
	);

	// register copies and the loaded mask bytes
	logic signed [12:0] left_pos;
	logic signed [12:0] eye_shift;
	logic [23:0]        overlay_color;
	logic [12:0]        mwidth;
	logic [12:0]        mheight;
	logic [12:0]        owidth;
	logic [7:0]         mask_copy [int];

	smc420_pkg::result_t pixels_due [$];
	int      fail_count = 0;
	int      items_sent = 0;
	int      cycle_count = 0;
	bit      item_up = 1'b0;
	bit      tx_calm = 1'b0;
	bit      dirty = 1'b0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// idle length: mostly none or short, now and then long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// store address read for pixel k of a quad; 0 when the pixel reads nothing
	function automatic bit mask_read(input logic [10:0] qx, input logic [10:0] qy,
			input logic eye_sel, input int k, output int addr);
		longint pos, x, y, rel, lin;
		addr = 0;
		pos = longint'(left_pos) + (eye_sel ? longint'(eye_shift) : 64'sd0);
		x = 2 * longint'(qx) + (k & 1);
		y = 2 * longint'(qy) + (k >> 1);
		rel = x - pos;
		if (qy >= (mheight >> 1) || qx >= (owidth >> 1))
			return 1'b0;
		if (rel < 0 || rel >= longint'(mwidth))
			return 1'b0;
		lin = y * longint'(mwidth) + rel;
		if (lin >= smc420_pkg::MASK_BUFFER_BYTES_DEF)
			return 1'b0;
		addr = int'(lin);
		return 1'b1;
	endfunction

	// four pixel results of one quad
	function automatic void colorize_quad(input logic [10:0] qx, input logic [10:0] qy,
			input logic eye_sel);
		int alpha [4];
		int addr, sum, sum_inv, avg, avg_inv, wy, wu, wv;
		smc420_pkg::result_t px;
		sum = 0;
		sum_inv = 0;
		for (int k = 0; k < 4; k++) begin
			alpha[k] = mask_read(qx, qy, eye_sel, k, addr) ? int'(mask_copy[addr]) : 0;
			sum += alpha[k];
			sum_inv += 255 - alpha[k];
		end
		avg = sum / 4;
		avg_inv = sum_inv / 4;
		wu = avg * int'(overlay_color[15:8]);
		wv = avg * int'(overlay_color[7:0]);
		for (int k = 0; k < 4; k++) begin
			wy = alpha[k] * int'(overlay_color[23:16]);
			px.pixel_index = 2'(k);
			px.luma_weighted = 16'(wy);
			px.inverse_alpha = 8'(255 - alpha[k]);
			px.letterbox_luma = 8'(wy / 255);
			px.chroma_u_weighted = 16'(wu);
			px.chroma_v_weighted = 16'(wv);
			px.chroma_inverse_alpha = 8'(avg_inv);
			px.letterbox_u = 8'((wu + 128 * avg_inv) / 255);
			px.letterbox_v = 8'((wv + 128 * avg_inv) / 255);
			px.last = (k == 3);
			pixels_due.push_back(px);
		end
	endfunction

	function automatic smc420_pkg::item_t random_item(input logic cmd);
		smc420_pkg::item_t it;
		it.command = cmd;
		it.load_address = 18'($urandom);
		it.load_value = 8'($urandom);
		it.quad_x = 11'($urandom);
		it.quad_y = 11'($urandom);
		it.eye = 1'($urandom);
		return it;
	endfunction

	// one input transaction; the prediction follows its acceptance
	task automatic send_item(input smc420_pkg::item_t it, input bit typed,
			input smc420_pkg::result_t want);
		int gap;
		smc420_pkg::result_t px;
		gap = tx_calm ? 0 : pick_gap();
		if (gap > 0) begin
			if (item_up)
				item_ch.valid <= 1'b0;
			item_up = 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.data <= it;
		item_up = 1'b1;
		do @(posedge clk); while (item_ch.ready !== 1'b1);
		items_sent++;
		dirty = 1'b1;
		if (it.command == smc420_pkg::CMD_LOAD) begin
			if (int'(it.load_address) < smc420_pkg::MASK_BUFFER_BYTES_DEF)
				mask_copy[int'(it.load_address)] = it.load_value;
		end else if (typed) begin
			for (int k = 0; k < 4; k++) begin
				px = want;
				px.pixel_index = 2'(k);
				px.last = (k == 3);
				pixels_due.push_back(px);
			end
		end else begin
			colorize_quad(it.quad_x, it.quad_y, it.eye);
		end
		if ($urandom_range(0, 29) == 0)
			tx_calm = !tx_calm;
	endtask

	// load every byte the quad reads that was never loaded, then send the quad
	task automatic send_quad(input logic [10:0] qx, input logic [10:0] qy, input logic eye_sel,
			input bit typed, input smc420_pkg::result_t want);
		int addr;
		smc420_pkg::item_t it;
		for (int k = 0; k < 4; k++) begin
			if (mask_read(qx, qy, eye_sel, k, addr) && !mask_copy.exists(addr)) begin
				it = random_item(smc420_pkg::CMD_LOAD);
				it.load_address = 18'(addr);
				send_item(it, 1'b0, '0);
			end
		end
		it = random_item(smc420_pkg::CMD_QUAD);
		it.quad_x = qx;
		it.quad_y = qy;
		it.eye = eye_sel;
		send_item(it, typed, want);
	endtask

	// stop sending and wait until the block is idle
	task automatic settle();
		if (item_up)
			item_ch.valid <= 1'b0;
		item_up = 1'b0;
		if (dirty) begin
			while (pixels_due.size() != 0) @(posedge clk);
			repeat (SETTLE_CYCLES) @(posedge clk);
			dirty = 1'b0;
		end
	endtask

	task automatic write_reg(input smc420_pkg::reg_idx_t idx, input logic [23:0] val);
		settle();
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.value <= val;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		cfg_ch.valid <= 1'b0;
		case (idx)
			smc420_pkg::REG_MASK_LEFT:   left_pos = val[12:0];
			smc420_pkg::REG_EYE_OFFSET:  eye_shift = val[12:0];
			smc420_pkg::REG_MASK_COLOR:  overlay_color = val;
			smc420_pkg::REG_MASK_WIDTH:  mwidth = val[12:0];
			smc420_pkg::REG_MASK_HEIGHT: mheight = val[12:0];
			smc420_pkg::REG_OUT_WIDTH:   owidth = val[12:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	// new setting for a random phase: mostly small masks, sometimes extremes
	task automatic random_setting();
		logic [12:0] w, h, ow, l, o;
		logic [23:0] c;
		if ($urandom_range(0, 5) == 0) begin
			w = $urandom_range(0, 1) ? 13'd4096 : 13'($urandom_range(0, 4096));
			h = $urandom_range(0, 1) ? 13'd4096 : 13'($urandom_range(0, 4096));
			ow = $urandom_range(0, 1) ? 13'd4096 : 13'($urandom_range(0, 4096));
			l = 13'($urandom);
			o = 13'($urandom);
		end else begin
			w = 13'($urandom_range(1, 24));
			h = 13'($urandom_range(0, 16));
			ow = 13'($urandom_range(0, 40));
			l = 13'($urandom_range(0, 16) - 6);
			o = 13'($urandom_range(0, 8) - 4);
		end
		case ($urandom_range(0, 7))
			0: c = 24'h000000;
			1: c = 24'hFFFFFF;
			default: c = 24'($urandom);
		endcase
		write_reg(smc420_pkg::REG_MASK_LEFT, 24'(l));
		write_reg(smc420_pkg::REG_EYE_OFFSET, 24'(o));
		write_reg(smc420_pkg::REG_MASK_COLOR, c);
		write_reg(smc420_pkg::REG_MASK_WIDTH, 24'(w));
		write_reg(smc420_pkg::REG_MASK_HEIGHT, 24'(h));
		write_reg(smc420_pkg::REG_OUT_WIDTH, 24'(ow));
	endtask

	// mask refreshes and quads over the window, plus some noise, up to the item budget
	task automatic random_phase(input int stop_at);
		int n, span;
		smc420_pkg::item_t it;
		n = $urandom_range(10, 30);
		for (int j = 0; j < n && items_sent < stop_at; j++) begin
			case ($urandom_range(0, 9))
				7: begin
					span = int'(mwidth) * int'(mheight);
					if (span > smc420_pkg::MASK_BUFFER_BYTES_DEF)
						span = smc420_pkg::MASK_BUFFER_BYTES_DEF;
					it = random_item(smc420_pkg::CMD_LOAD);
					if (span > 0)
						it.load_address = 18'($urandom_range(0, span - 1));
					send_item(it, 1'b0, '0);
				end
				8: send_item(random_item(smc420_pkg::CMD_LOAD), 1'b0, '0);
				9: send_quad(11'($urandom), 11'($urandom), 1'($urandom), 1'b0, '0);
				default: send_quad(
					11'($urandom_range(0, (owidth >> 1) > 2047 ? 2047 : (owidth >> 1))),
					11'($urandom_range(0, (mheight >> 1) > 2047 ? 2047 : (mheight >> 1))),
					1'($urandom), 1'b0, '0);
			endcase
		end
	endtask

	task automatic match_field(input string name, input logic [15:0] want_v,
			input logic [15:0] got_v);
		if (got_v !== want_v) begin
			$display("%0t mismatch %s: expected %0d actual %0d", $time, name, want_v, got_v);
			fail_count++;
		end
	endtask

	task automatic take_pixel(input smc420_pkg::result_t got);
		smc420_pkg::result_t want;
		if (pixels_due.size() == 0) begin
			$display("%0t unexpected result: expected none actual %h", $time, got);
			fail_count++;
			return;
		end
		want = pixels_due.pop_front();
		match_field("pixel_index", 16'(want.pixel_index), 16'(got.pixel_index));
		match_field("luma_weighted", want.luma_weighted, got.luma_weighted);
		match_field("inverse_alpha", 16'(want.inverse_alpha), 16'(got.inverse_alpha));
		match_field("letterbox_luma", 16'(want.letterbox_luma), 16'(got.letterbox_luma));
		match_field("chroma_u_weighted", want.chroma_u_weighted, got.chroma_u_weighted);
		match_field("chroma_v_weighted", want.chroma_v_weighted, got.chroma_v_weighted);
		match_field("chroma_inverse_alpha", 16'(want.chroma_inverse_alpha),
			16'(got.chroma_inverse_alpha));
		match_field("letterbox_u", 16'(want.letterbox_u), 16'(got.letterbox_u));
		match_field("letterbox_v", 16'(want.letterbox_v), 16'(got.letterbox_v));
		match_field("last", 16'(want.last), 16'(got.last));
	endtask

	// result side: check each transaction, stall at random
	initial begin
		int stall_left;
		bit rx_calm;
		stall_left = 0;
		rx_calm = 1'b0;
		res_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
				take_pixel(res_ch.data);
			if ($urandom_range(0, 199) == 0)
				rx_calm = !rx_calm;
			if (stall_left > 0) begin
				stall_left--;
				res_ch.ready <= 1'b0;
			end else if (!rx_calm && $urandom_range(0, 5) == 0) begin
				stall_left = pick_gap();
				res_ch.ready <= (stall_left == 0);
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	// reset, directed table, random phases, drain
	initial begin
		smc420_pkg::item_t it;
		int base;
		arst_n = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.data = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.value = '0;
		left_pos = '0;
		eye_shift = '0;
		overlay_color = smc420_pkg::MASK_COLOR_RST;
		mwidth = '0;
		mheight = '0;
		owidth = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < N_STEPS; i++) begin
			case (steps[i].kind)
				STEP_CFG: write_reg(smc420_pkg::reg_idx_t'(steps[i].a), 24'(steps[i].b));
				STEP_LOAD: begin
					it = random_item(smc420_pkg::CMD_LOAD);
					it.load_address = 18'(steps[i].a);
					it.load_value = 8'(steps[i].b);
					send_item(it, 1'b0, '0);
				end
				default: send_quad(11'(steps[i].a), 11'(steps[i].b), steps[i].eye_sel,
					steps[i].typed, steps[i].want);
			endcase
		end

		base = items_sent;
		while (items_sent - base < RANDOM_ITEMS) begin
			random_setting();
			random_phase(base + RANDOM_ITEMS);
		end

		settle();
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
